// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL. Define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/rau_pkg.sv
package rau_pkg;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam logic [1:0] CMD_MUL = 2'd2;
    localparam logic [1:0] CMD_DIV = 2'd3;

    localparam int PC_W = 5;
    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [3:0] {
        U_NOP,
        U_NUM_LOAD,
        U_NUM_ADD,
        U_NUM_SUB,
        U_DEN_LOAD,
        U_SETUP,
        U_GCD_STEP,
        U_DIV_INIT,
        U_DIV_STEP,
        U_OUT_OK,
        U_OUT_ERR
    } uop_t;

    typedef enum logic [1:0] {
        M_AN_BD,
        M_AD_BN,
        M_AN_BN,
        M_AD_BD
    } mul_sel_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_DEN_ZERO,
        C_GCD_BUSY,
        C_DIV_BUSY
    } cond_t;

    typedef struct packed {
        uop_t     uop;
        mul_sel_t mul_sel;
        cond_t    cond;
        pc_t      target;
    } ctrl_t;

    typedef struct packed {
        logic den_zero;
        logic gcd_busy;
        logic div_busy;
        logic out_block;
    } status_t;

    // Microprogram entry points and labels
    localparam pc_t PC_ADD     = 5'd0;
    localparam pc_t PC_SUB     = 5'd4;
    localparam pc_t PC_MUL     = 5'd8;
    localparam pc_t PC_DIV     = 5'd11;
    localparam pc_t PC_SETUP   = 5'd14;
    localparam pc_t PC_GCD     = 5'd15;
    localparam pc_t PC_DIVINIT = 5'd16;
    localparam pc_t PC_DIVSTEP = 5'd17;
    localparam pc_t PC_OUT     = 5'd18;
    localparam pc_t PC_ERR     = 5'd19;

    function automatic ctrl_t uword(uop_t u, mul_sel_t m, cond_t c, pc_t t);
        ctrl_t w;
        w.uop     = u;
        w.mul_sel = m;
        w.cond    = c;
        w.target  = t;
        return w;
    endfunction

    function automatic pc_t entry_pc(logic [1:0] cmd);
        pc_t pc;
        unique case (cmd)
            CMD_ADD: pc = PC_ADD;
            CMD_SUB: pc = PC_SUB;
            CMD_MUL: pc = PC_MUL;
            CMD_DIV: pc = PC_DIV;
            default: pc = PC_ERR;
        endcase
        return pc;
    endfunction

    // Control store. The product register is loaded from the multiplier every
    // step, so each accumulate picks up the product issued on the step before.
    function automatic ctrl_t ucode_rom(pc_t pc);
        ctrl_t w;
        unique case (pc)
            // add
            5'd0:  w = uword(U_NOP,      M_AN_BD, C_NEXT,     PC_SETUP);
            5'd1:  w = uword(U_NUM_LOAD, M_AD_BN, C_NEXT,     PC_SETUP);
            5'd2:  w = uword(U_NUM_ADD,  M_AD_BD, C_NEXT,     PC_SETUP);
            5'd3:  w = uword(U_DEN_LOAD, M_AD_BD, C_JUMP,     PC_SETUP);
            // subtract
            5'd4:  w = uword(U_NOP,      M_AN_BD, C_NEXT,     PC_SETUP);
            5'd5:  w = uword(U_NUM_LOAD, M_AD_BN, C_NEXT,     PC_SETUP);
            5'd6:  w = uword(U_NUM_SUB,  M_AD_BD, C_NEXT,     PC_SETUP);
            5'd7:  w = uword(U_DEN_LOAD, M_AD_BD, C_JUMP,     PC_SETUP);
            // multiply
            5'd8:  w = uword(U_NOP,      M_AN_BN, C_NEXT,     PC_SETUP);
            5'd9:  w = uword(U_NUM_LOAD, M_AD_BD, C_NEXT,     PC_SETUP);
            5'd10: w = uword(U_DEN_LOAD, M_AD_BD, C_JUMP,     PC_SETUP);
            // divide
            5'd11: w = uword(U_NOP,      M_AN_BD, C_NEXT,     PC_SETUP);
            5'd12: w = uword(U_NUM_LOAD, M_AD_BN, C_NEXT,     PC_SETUP);
            5'd13: w = uword(U_DEN_LOAD, M_AD_BN, C_NEXT,     PC_SETUP);
            // common reduction
            5'd14: w = uword(U_SETUP,    M_AD_BD, C_DEN_ZERO, PC_ERR);
            5'd15: w = uword(U_GCD_STEP, M_AD_BD, C_GCD_BUSY, PC_GCD);
            5'd16: w = uword(U_DIV_INIT, M_AD_BD, C_NEXT,     PC_DIVSTEP);
            5'd17: w = uword(U_DIV_STEP, M_AD_BD, C_DIV_BUSY, PC_DIVSTEP);
            5'd18: w = uword(U_OUT_OK,   M_AD_BD, C_NEXT,     PC_OUT);
            5'd19: w = uword(U_OUT_ERR,  M_AD_BD, C_NEXT,     PC_ERR);
            default: w = uword(U_OUT_ERR, M_AD_BD, C_NEXT,    PC_ERR);
        endcase
        return w;
    endfunction

endpackage

// File: rtl/rau_seq.sv
module rau_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        cmd,
    input  rau_pkg::status_t  status,
    output rau_pkg::ctrl_t    ctrl,
    output logic              busy
);
    import rau_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } seq_state_t;

    seq_state_t state_reg, state_next;
    pc_t        upc_reg, upc_next;
    ctrl_t      word;
    logic       is_out;
    logic       stall;
    logic       take;

    assign word   = ucode_rom(upc_reg);
    assign is_out = (word.uop == U_OUT_OK) || (word.uop == U_OUT_ERR);
    // Hold the result step while the previous result is still unclaimed
    assign stall  = is_out && status.out_block;
    assign busy   = (state_reg == ST_RUN);

    always_comb
    begin
        unique case (word.cond)
            C_NEXT:     take = 1'b0;
            C_JUMP:     take = 1'b1;
            C_DEN_ZERO: take = status.den_zero;
            C_GCD_BUSY: take = status.gcd_busy;
            C_DIV_BUSY: take = status.div_busy;
            default:    take = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        upc_next   = upc_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                    upc_next   = entry_pc(cmd);
                end
            end
            ST_RUN:
            begin
                if (!stall)
                begin
                    if (is_out)
                        state_next = ST_IDLE;
                    else if (take)
                        upc_next = word.target;
                    else
                        upc_next = PC_W'(upc_reg + 1'b1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = word;
        if (!busy || stall)
            ctrl.uop = U_NOP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            upc_reg   <= PC_ADD;
        end
        else
        begin
            state_reg <= state_next;
            upc_reg   <= upc_next;
        end
    end

endmodule

// File: rtl/rau_dp.sv
module rau_dp #(
    parameter int WIDTH = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  logic signed [WIDTH-1:0] a_num,
    input  logic [WIDTH-2:0]        a_den,
    input  logic signed [WIDTH-1:0] b_num,
    input  logic [WIDTH-2:0]        b_den,
    input  rau_pkg::ctrl_t          ctrl,
    input  logic                    out_ready,
    output rau_pkg::status_t        status,
    output logic signed [31:0]      res_num,
    output logic [30:0]             res_den,
    output logic                    div_error,
    output logic                    out_valid
);
    import rau_pkg::*;

    localparam int PW = 2 * WIDTH;
    localparam int M  = PW - 1;
    localparam int KW = $clog2(M);
    localparam int XN = (M + 1 > 32) ? M + 1 : 32;
    localparam int XD = (M > 31) ? M : 31;

    logic signed [WIDTH-1:0] an_reg, an_next, bn_reg, bn_next;
    logic [WIDTH-2:0]        ad_reg, ad_next, bd_reg, bd_next;
    logic signed [PW-1:0]    p_reg, p_next;
    logic signed [PW-1:0]    num_reg, num_next, den_reg, den_next;
    logic [M-1:0]            x_reg, x_next, y_reg, y_next;
    logic [M-1:0]            m_reg, m_next, d_reg, d_next;
    logic [M-1:0]            g_reg, g_next;
    logic [KW-1:0]           k_reg, k_next, cnt_reg, cnt_next;
    logic                    neg_reg, neg_next;
    logic signed [31:0]      res_num_reg, res_num_next;
    logic [30:0]             res_den_reg, res_den_next;
    logic                    err_reg, err_next;
    logic                    out_valid_reg, out_valid_next;

    logic signed [WIDTH-1:0] opa, opb;
    logic signed [PW-1:0]    prod;
    logic [PW-1:0]           num_abs, den_abs;
    logic                    gcd_busy;
    logic [M-1:0]            diff_xy, diff_yx, gcd_val;
    logic [M:0]              rm_wide, rd_wide, rm_sub, rd_sub;
    logic                    rm_ge, rd_ge;
    logic [M-1:0]            rm_new, rd_new;
    logic signed [M:0]       num_s;
    logic signed [XN-1:0]    num_ext;
    logic [XD-1:0]           den_ext;

    // Shared multiplier: one product per step
    always_comb
    begin
        unique case (ctrl.mul_sel)
            M_AN_BD:
            begin
                opa = an_reg;
                opb = $signed({1'b0, bd_reg});
            end
            M_AD_BN:
            begin
                opa = $signed({1'b0, ad_reg});
                opb = bn_reg;
            end
            M_AN_BN:
            begin
                opa = an_reg;
                opb = bn_reg;
            end
            M_AD_BD:
            begin
                opa = $signed({1'b0, ad_reg});
                opb = $signed({1'b0, bd_reg});
            end
            default:
            begin
                opa = an_reg;
                opb = bn_reg;
            end
        endcase
    end

    assign prod = PW'(opa) * PW'(opb);

    assign num_abs = num_reg[PW-1] ? -num_reg : num_reg;
    assign den_abs = den_reg[PW-1] ? -den_reg : den_reg;

    // Binary gcd datapath
    assign gcd_busy = (x_reg != '0) && (y_reg != '0);
    assign diff_xy  = x_reg - y_reg;
    assign diff_yx  = y_reg - x_reg;
    assign gcd_val  = (x_reg | y_reg) << k_reg;

    // Two restoring-division lanes sharing the divisor
    assign rm_wide = {x_reg, m_reg[M-1]};
    assign rd_wide = {y_reg, d_reg[M-1]};
    assign rm_sub  = rm_wide - {1'b0, g_reg};
    assign rd_sub  = rd_wide - {1'b0, g_reg};
    assign rm_ge   = rm_wide >= {1'b0, g_reg};
    assign rd_ge   = rd_wide >= {1'b0, g_reg};
    assign rm_new  = rm_ge ? rm_sub[M-1:0] : rm_wide[M-1:0];
    assign rd_new  = rd_ge ? rd_sub[M-1:0] : rd_wide[M-1:0];

    // Apply sign and fit to the output field widths
    assign num_s   = neg_reg ? -$signed({1'b0, m_reg}) : $signed({1'b0, m_reg});
    assign num_ext = XN'(num_s);
    assign den_ext = XD'(d_reg);

    always_comb
    begin
        an_next        = an_reg;
        ad_next        = ad_reg;
        bn_next        = bn_reg;
        bd_next        = bd_reg;
        p_next         = prod;
        num_next       = num_reg;
        den_next       = den_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        m_next         = m_reg;
        d_next         = d_reg;
        g_next         = g_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        res_num_next   = res_num_reg;
        res_den_next   = res_den_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;

        if (out_ready)
            out_valid_next = 1'b0;

        if (load)
        begin
            an_next = a_num;
            ad_next = a_den;
            bn_next = b_num;
            bd_next = b_den;
        end

        unique case (ctrl.uop)
            U_NUM_LOAD: num_next = p_reg;
            U_NUM_ADD:  num_next = num_reg + p_reg;
            U_NUM_SUB:  num_next = num_reg - p_reg;
            U_DEN_LOAD: den_next = p_reg;
            U_SETUP:
            begin
                x_next   = num_abs[M-1:0];
                y_next   = den_abs[M-1:0];
                m_next   = num_abs[M-1:0];
                d_next   = den_abs[M-1:0];
                neg_next = num_reg[PW-1] ^ den_reg[PW-1];
                k_next   = '0;
            end
            U_GCD_STEP:
            begin
                if (gcd_busy)
                begin
                    priority if (!x_reg[0] && !y_reg[0])
                    begin
                        x_next = x_reg >> 1;
                        y_next = y_reg >> 1;
                        k_next = KW'(k_reg + 1'b1);
                    end
                    else if (!x_reg[0])
                        x_next = x_reg >> 1;
                    else if (!y_reg[0])
                        y_next = y_reg >> 1;
                    else if (x_reg >= y_reg)
                        x_next = diff_xy >> 1;
                    else
                        y_next = diff_yx >> 1;
                end
            end
            U_DIV_INIT:
            begin
                g_next   = gcd_val;
                x_next   = '0;
                y_next   = '0;
                cnt_next = '0;
            end
            U_DIV_STEP:
            begin
                x_next   = rm_new;
                y_next   = rd_new;
                m_next   = {m_reg[M-2:0], rm_ge};
                d_next   = {d_reg[M-2:0], rd_ge};
                cnt_next = KW'(cnt_reg + 1'b1);
            end
            U_OUT_OK:
            begin
                res_num_next   = num_ext[31:0];
                res_den_next   = den_ext[30:0];
                err_next       = 1'b0;
                out_valid_next = 1'b1;
            end
            U_OUT_ERR:
            begin
                res_num_next   = '0;
                res_den_next   = '0;
                err_next       = 1'b1;
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        an_reg      <= an_next;
        ad_reg      <= ad_next;
        bn_reg      <= bn_next;
        bd_reg      <= bd_next;
        p_reg       <= p_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        m_reg       <= m_next;
        d_reg       <= d_next;
        g_reg       <= g_next;
        k_reg       <= k_next;
        cnt_reg     <= cnt_next;
        neg_reg     <= neg_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        err_reg     <= err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign status.den_zero  = (den_reg == '0);
    assign status.gcd_busy  = gcd_busy;
    assign status.div_busy  = (cnt_reg != KW'(M - 1));
    assign status.out_block = out_valid_reg && !out_ready;

    assign res_num   = res_num_reg;
    assign res_den   = res_den_reg;
    assign div_error = err_reg;
    assign out_valid = out_valid_reg;

endmodule

// File: rtl/rational_arithmetic_unit_top.sv
// Rational arithmetic unit: combines a_num/a_den and b_num/b_den by cmd
// (add, subtract, multiply, divide) and returns the result in lowest terms,
// sign on res_num, res_den positive. Dividing by a zero numerator (or any
// zero denominator product) gives 0/0 with div_error set. One item is worked
// at a time; the next item is taken as soon as the current one has written
// its result register, even if that result has not yet been read. Each item
// forms its products on a single shared multiplier, then runs the binary
// gcd loop, whose length depends on the operands, and the bit-serial
// division by the gcd (one quotient bit a cycle, numerator and denominator
// lanes in parallel) before writing its result. A zero denominator product
// skips the reduction. A result left unclaimed holds the next item at its
// result step until the receiver takes it.
`include "assert_macros.svh"

module rational_arithmetic_unit_top #(
    parameter int WIDTH = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              cmd,
    input  logic signed [WIDTH-1:0] a_num,
    input  logic [WIDTH-2:0]        a_den,
    input  logic signed [WIDTH-1:0] b_num,
    input  logic [WIDTH-2:0]        b_den,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [31:0]      res_num,
    output logic [30:0]             res_den,
    output logic                    div_error
);
    import rau_pkg::*;

    logic    busy;
    logic    start;
    ctrl_t   ctrl;
    status_t status;

    // Take a new item whenever the sequencer is parked
    assign in_ready = !busy;
    assign start    = in_valid && in_ready;

    // Microprogram sequencer: step counter, control store, jump logic
    rau_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    // Datapath: operand latch, multiplier, accumulator, gcd, divider, result
    rau_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (start),
        .a_num     (a_num),
        .a_den     (a_den),
        .b_num     (b_num),
        .b_den     (b_den),
        .ctrl      (ctrl),
        .out_ready (out_ready),
        .status    (status),
        .res_num   (res_num),
        .res_den   (res_den),
        .div_error (div_error),
        .out_valid (out_valid)
    );

    // An accepted item keeps the unit busy on the following cycle
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, start, !in_ready, "accepted item did not start")

    // A result step that issues lands in the output register and frees the input
    `ASSERT_NEXT(a_result_lands, clk, rst_n, ctrl.uop == U_OUT_OK || ctrl.uop == U_OUT_ERR, out_valid && in_ready, "result step lost")

    // An error result always reads 0/0
    `ASSERT_IMPLIES(a_error_zero, clk, rst_n, out_valid && div_error, res_num == 0 && res_den == 0, "error result not 0/0")

endmodule

// File: dv/rational_arithmetic_unit_top_test.sv
module rational_arithmetic_unit_top_test;

    import rau_pkg::*;

    localparam int W = 16;

    // Long enough for every item at its slowest gcd loop plus both sides stalling,
    // taken several times over.
    localparam int RUN_LIMIT = 10_000_000;

    // Receiver hold-off used to back the block up until it drops in_ready.
    localparam int HOLD_OFF_CYCLES = 600;

    // Settle time after the last result, well above one item's worst latency.
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic               err;
    } fraction_result_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          cmd;
    logic signed [W-1:0] a_num;
    logic [W-2:0]        a_den;
    logic signed [W-1:0] b_num;
    logic [W-2:0]        b_den;
    logic                out_valid;
    logic                out_ready;
    logic signed [31:0]  res_num;
    logic [30:0]         res_den;
    logic                div_error;

    // Results owed by the block, oldest first.
    fraction_result_t pending_results[$];
    int               mismatch_count = 0;

    // Idling knobs for the sender task and the receiver process.
    bit sender_gaps   = 1'b1;
    bit sink_stalls   = 1'b1;
    bit hold_off_req  = 1'b0;

    rational_arithmetic_unit_top #(
        .WIDTH(W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .a_num    (a_num),
        .a_den    (a_den),
        .b_num    (b_num),
        .b_den    (b_den),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .res_num  (res_num),
        .res_den  (res_den),
        .div_error(div_error)
    );

    always #5 clk = ~clk;

    // Predict one result: form the unreduced fraction from the cross or
    // straight products, flag a zero denominator, otherwise reduce by the
    // gcd of the magnitudes and move the sign onto the numerator.
    function automatic fraction_result_t compute_rational(
        input logic [1:0]          op,
        input logic signed [W-1:0] an_in,
        input logic [W-2:0]        ad_in,
        input logic signed [W-1:0] bn_in,
        input logic [W-2:0]        bd_in
    );
        fraction_result_t  r;
        longint            an, ad, bn, bd, num, den;
        longint unsigned   mag, dmag, x, y, t;
        logic              neg;
        an = an_in;
        ad = ad_in;
        bn = bn_in;
        bd = bd_in;
        case (op)
            CMD_ADD:
            begin
                num = an * bd + ad * bn;
                den = ad * bd;
            end
            CMD_SUB:
            begin
                num = an * bd - ad * bn;
                den = ad * bd;
            end
            CMD_MUL:
            begin
                num = an * bn;
                den = ad * bd;
            end
            default:
            begin
                // Divide: multiply by the reciprocal, sign may land on den.
                num = an * bd;
                den = ad * bn;
            end
        endcase
        if (den == 0)
        begin
            r.num = '0;
            r.den = '0;
            r.err = 1'b1;
            return r;
        end
        neg  = (num < 0) != (den < 0);
        mag  = (num < 0) ? -num : num;
        dmag = (den < 0) ? -den : den;
        x = mag;
        y = dmag;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        if (x == 0)
            x = 1;
        mag  = mag / x;
        dmag = dmag / x;
        if (neg)
            mag = 0 - mag;
        r.num = mag[31:0];
        r.den = dmag[30:0];
        r.err = 1'b0;
        return r;
    endfunction

    // Record each accepted item's prediction and check each accepted result
    // against the oldest one. Pushing before popping keeps the order right
    // even if both handshakes land on the same edge.
    always @(posedge clk)
    begin : scoreboard
        fraction_result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                pending_results.push_back(compute_rational(cmd, a_num, a_den, b_num, b_den));
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with none pending: %0d/%0d err %0b",
                             $time, res_num, res_den, div_error);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (res_num !== want.num)
                    begin
                        $display("%0t: res_num expected %0d, actual %0d",
                                 $time, want.num, res_num);
                        mismatch_count++;
                    end
                    if (res_den !== want.den)
                    begin
                        $display("%0t: res_den expected %0d, actual %0d",
                                 $time, want.den, res_den);
                        mismatch_count++;
                    end
                    if (div_error !== want.err)
                    begin
                        $display("%0t: div_error expected %0b, actual %0b",
                                 $time, want.err, div_error);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Receiver: drop out_ready in random bursts, or for one long stretch on
    // request so that the result register stays full and the block stalls.
    initial
    begin : result_sink
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (sink_stalls && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Offer one item and hold it until accepted. Called just after the clock
    // rises; an idle burst, if any, goes in front of the item.
    task automatic send_operands(
        input logic [1:0]          op,
        input logic signed [W-1:0] an,
        input logic [W-2:0]        ad,
        input logic signed [W-1:0] bn,
        input logic [W-2:0]        bd
    );
        int unsigned gap;
        if (sender_gaps && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        a_num    <= an;
        a_den    <= ad;
        b_num    <= bn;
        b_den    <= bd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Numerators: extremes, zero, small values that reduce often, and
    // full-range values.
    function automatic logic signed [W-1:0] pick_numerator();
        logic signed [W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            1:       v = '0;
            2, 3, 4:
            begin
                v = W'($urandom_range(0, 40));
                v = v - 16'sd20;
            end
            default: v = W'($urandom);
        endcase
        return v;
    endfunction

    // Denominators: occasionally zero (outside the nominal range), the top
    // value, small values and full range.
    function automatic logic [W-2:0] pick_denominator();
        logic [W-2:0] v;
        case ($urandom_range(0, 49))
            0:               v = '0;
            1, 2:            v = 15'h7fff;
            3, 4, 5, 6, 7,
            8, 9, 10, 11, 12,
            13, 14, 15, 16:  v = (W-1)'($urandom_range(1, 24));
            default:         v = (W-1)'($urandom_range(1, 32767));
        endcase
        return v;
    endfunction

    // Extremes of every field, each operation, zero results, divide by a
    // zero numerator and zero denominator operands.
    task automatic run_corner_cases();
        send_operands(CMD_ADD, 16'sd1, 15'd2, 16'sd1, 15'd3);
        send_operands(CMD_SUB, 16'sd1, 15'd2, 16'sd1, 15'd2);
        send_operands(CMD_MUL, -16'sd3, 15'd4, 16'sd2, 15'd3);
        send_operands(CMD_DIV, 16'sd3, 15'd4, -16'sd3, 15'd8);
        send_operands(CMD_DIV, 16'sd1, 15'd2, 16'sd0, 15'd5);
        send_operands(CMD_DIV, 16'sd0, 15'd1, 16'sd0, 15'd1);
        send_operands(CMD_ADD, 16'sh7fff, 15'd1, 16'sh7fff, 15'd1);
        send_operands(CMD_ADD, 16'sh8000, 15'h7fff, 16'sh8000, 15'h7fff);
        send_operands(CMD_SUB, 16'sh8000, 15'd1, 16'sh7fff, 15'd1);
        send_operands(CMD_SUB, 16'sh7fff, 15'h7fff, 16'sh8000, 15'h7fff);
        send_operands(CMD_MUL, 16'sh8000, 15'd1, 16'sh8000, 15'd1);
        send_operands(CMD_MUL, 16'sh7fff, 15'h7fff, 16'sh7fff, 15'h7fff);
        send_operands(CMD_DIV, 16'sh8000, 15'd1, 16'sh8000, 15'h7fff);
        send_operands(CMD_DIV, 16'sd1, 15'h7fff, 16'sh7fff, 15'd1);
        send_operands(CMD_DIV, 16'sh7fff, 15'h7fff, -16'sd1, 15'h7fff);
        // Zero denominator operands.
        send_operands(CMD_ADD, 16'sd1, 15'd0, 16'sd1, 15'd1);
        send_operands(CMD_MUL, 16'sd5, 15'd3, 16'sd2, 15'd0);
        send_operands(CMD_DIV, 16'sd7, 15'd0, 16'sd5, 15'd3);
        send_operands(CMD_SUB, 16'sd0, 15'd0, 16'sd0, 15'd0);
        // Zero results with nonzero denominators, then a negative whole result.
        send_operands(CMD_MUL, 16'sd0, 15'd7, 16'sd5, 15'd3);
        send_operands(CMD_ADD, 16'sd7, 15'd15, -16'sd7, 15'd15);
        send_operands(CMD_DIV, 16'sd0, 15'd9, -16'sd4, 15'd1);
        send_operands(CMD_SUB, -16'sd1, 15'd1, 16'sd1, 15'd1);
    endtask

    // Random operations; re-roll both idling knobs every hundred items so
    // stretches with and without idling alternate.
    task automatic run_random_mix(input int count);
        for (int n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
            begin
                sender_gaps = ($urandom_range(0, 3) != 0);
                sink_stalls = ($urandom_range(0, 3) != 0);
            end
            send_operands(2'($urandom_range(0, 3)), pick_numerator(), pick_denominator(),
                          pick_numerator(), pick_denominator());
        end
    endtask

    // Hold the receiver off while items keep coming, so the block fills up
    // and stalls its input; then release and let it drain.
    task automatic run_output_backpressure(input int count);
        sender_gaps  = 1'b0;
        hold_off_req = 1'b1;
        for (int n = 0; n < count; n++)
            send_operands(2'($urandom_range(0, 3)), pick_numerator(), pick_denominator(),
                          pick_numerator(), pick_denominator());
        wait (!hold_off_req);
        sender_gaps = 1'b1;
    endtask

    // Final stretch: no idling on either side.
    task automatic run_back_to_back(input int count);
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        for (int n = 0; n < count; n++)
            send_operands(2'($urandom_range(0, 3)), pick_numerator(), pick_denominator(),
                          pick_numerator(), pick_denominator());
    endtask

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        cmd      = CMD_ADD;
        a_num    = '0;
        a_den    = '0;
        b_num    = '0;
        b_den    = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_corner_cases();
        run_random_mix(600);
        run_output_backpressure(16);
        run_random_mix(640);
        run_back_to_back(520);

        // Drop valid, wait out the owed results, then watch for strays.
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
